// ===== src/ipv4_longest_prefix_router_top_defines.svh =====
// assertion helpers shared by the route table rtl
`ifndef IPV4_LONGEST_PREFIX_ROUTER_TOP_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ILPR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("route table assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ILPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("route table assertion failed");

`endif

// ===== src/ilpr_pkg.sv =====
`timescale 1ns / 1ps

package ilpr_pkg;

  // defaults for the top level parameters
  localparam int TableDepthDef = 64;
  localparam int NumIfDef      = 16;

  // item kinds
  typedef enum logic [0:0] {
    FUNC_ADD   = 1'b0,
    FUNC_ROUTE = 1'b1
  } func_e;

  // result codes
  typedef enum logic [2:0] {
    ST_FORWARD  = 3'd0,
    ST_NO_ROUTE = 3'd1,
    ST_TTL      = 3'd2,
    ST_ADDED    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // one word as it walks down the cell chain, with the best match so far
  typedef struct packed {
    func_e       func;
    logic        full;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        has_nh;
    logic [31:0] gw;
    logic [3:0]  itf;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic        found;
    logic [5:0]  best_len;
    logic [32:0] best_gw;
    logic [3:0]  best_itf;
  } item_t;

  // high-order mask for a prefix length of 0 to 32
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else begin
      m = 32'hffff_ffff << (6'd32 - len);
    end
    return m;
  endfunction

endpackage

// ===== src/ilpr_cell.sv =====
`timescale 1ns / 1ps

module ilpr_cell #(
  parameter int CntW = 7,
  parameter int Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  ilpr_pkg::item_t item_i,
  input  logic [CntW-1:0] cnt_i,
  output logic            valid_o,
  output ilpr_pkg::item_t item_o,
  output logic [CntW-1:0] cnt_o
);
  import ilpr_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic [31:0] ent_prefix_q;
  logic [5:0]  ent_len_q;
  logic [32:0] ent_gw_q;
  logic [3:0]  ent_itf_q;

  logic        valid_q;
  item_t       item_q, item_d;
  logic [CntW-1:0] cnt_q;

  logic [31:0] mask;
  logic        hit;
  logic        wr;

  // route held by this cell is written by the add word whose slot is ours
  assign wr = valid_i && adv_i && (item_i.func == FUNC_ADD) && !item_i.full
              && (cnt_i == IdxC);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_prefix_q <= item_i.prefix;
      ent_len_q    <= item_i.len;
      ent_gw_q     <= {item_i.has_nh, item_i.gw};
      ent_itf_q    <= item_i.itf;
    end
  end

  // compare against the stored route, longer prefix wins, ties keep earlier
  assign mask = len_mask(ent_len_q);
  assign hit  = (item_i.func == FUNC_ROUTE) && (IdxC < cnt_i)
                && ((item_i.dst & mask) == (ent_prefix_q & mask))
                && (!item_i.found || (ent_len_q > item_i.best_len));

  always_comb begin
    item_d = item_i;
    if (hit) begin
      item_d.found    = 1'b1;
      item_d.best_len = ent_len_q;
      item_d.best_gw  = ent_gw_q;
      item_d.best_itf = ent_itf_q;
    end
  end

  // hand the word to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
      cnt_q  <= cnt_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign cnt_o   = cnt_q;

endmodule

// ===== src/ipv4_longest_prefix_router_top.sv =====
// IPv4 longest-prefix route table built as a chain of route cells.
// Input channel: in_valid_i / in_stall_o carry one word per accept. func_i = 0
// appends a route (prefix, length, optional gateway, interface) to the next
// free cell; func_i = 1 looks up dst_addr_i with ttl_in_i.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word, in input order: status, interface, next hop and decremented TTL.
// Each word walks through TABLE_DEPTH cell registers in turn, each cell holding
// one route and keeping the longest match seen so far; an output register
// follows. One word enters per cycle, so throughput is one word per cycle
// while the receiver keeps up.
// A route added by one word is seen by every later word, since the add walks
// the chain ahead of them.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset clears the route count and all valid flags; the table reads as empty
// right away, with no clearing pass.
`timescale 1ns / 1ps
`include "ipv4_longest_prefix_router_top_defines.svh"

module ipv4_longest_prefix_router_top #(
  parameter int TABLE_DEPTH    = ilpr_pkg::TableDepthDef,
  parameter int NUM_INTERFACES = ilpr_pkg::NumIfDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] route_prefix_i,
  input  logic [5:0]  prefix_length_i,
  input  logic        has_next_hop_i,
  input  logic [31:0] gateway_addr_i,
  input  logic [3:0]  interface_index_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  ttl_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  out_interface_o,
  output logic [31:0] next_hop_addr_o,
  output logic [7:0]  ttl_out_o
);
  import ilpr_pkg::*;

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  logic            adv;
  logic            in_acc;
  logic            full;
  logic [CntW-1:0] cnt_q;
  item_t           item_in;

  logic            valid_c [TABLE_DEPTH+1];
  item_t           item_c  [TABLE_DEPTH+1];
  logic [CntW-1:0] cnt_c   [TABLE_DEPTH+1];

  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [3:0]      itf_q, itf_d;
  logic [31:0]     hop_q, hop_d;
  logic [7:0]      ttl_q, ttl_d;
  item_t           last;

  // chain moves whenever the output register is free or being drained
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign full       = (cnt_q == DepthC);

  // route count, taken at accept so each word carries its own view
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && (func_i == FUNC_ADD) && !full) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // build the word entering the first cell
  always_comb begin
    item_in          = '0;
    item_in.func     = func_e'(func_i);
    item_in.full     = full;
    item_in.prefix   = route_prefix_i;
    item_in.len      = (prefix_length_i > 6'd32) ? 6'd32 : prefix_length_i;
    item_in.has_nh   = has_next_hop_i;
    item_in.gw       = gateway_addr_i;
    item_in.itf      = interface_index_i;
    item_in.dst      = dst_addr_i;
    item_in.ttl      = ttl_in_i;
  end

  assign valid_c[0] = in_valid_i;
  assign item_c[0]  = item_in;
  assign cnt_c[0]   = cnt_q;

  // one cell per route
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ilpr_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_c[g]),
      .item_i  (item_c[g]),
      .cnt_i   (cnt_c[g]),
      .valid_o (valid_c[g+1]),
      .item_o  (item_c[g+1]),
      .cnt_o   (cnt_c[g+1])
    );
  end

  // turn the best match into a result word
  assign last = item_c[TABLE_DEPTH];

  always_comb begin
    status_d = ST_NO_ROUTE;
    itf_d    = 4'h0;
    hop_d    = 32'h0;
    ttl_d    = 8'h0;
    if (last.func == FUNC_ADD) begin
      status_d = last.full ? ST_FULL : ST_ADDED;
    end else if (!last.found || (int'(last.best_itf) >= NUM_INTERFACES)) begin
      status_d = ST_NO_ROUTE;
    end else if (last.ttl <= 8'd1) begin
      status_d = ST_TTL;
    end else begin
      status_d = ST_FORWARD;
      itf_d    = last.best_itf;
      hop_d    = last.best_gw[32] ? last.best_gw[31:0] : last.dst;
      ttl_d    = last.ttl - 8'd1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_c[TABLE_DEPTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      itf_q    <= itf_d;
      hop_q    <= hop_d;
      ttl_q    <= ttl_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_interface_o = itf_q;
  assign next_hop_addr_o = hop_q;
  assign ttl_out_o       = ttl_q;

  // checks
  `ILPR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= DepthC)
  `ILPR_ASSERT_NEXT(a_cnt_hold, !(in_acc && (func_i == FUNC_ADD) && !full), $stable(cnt_q))
  `ILPR_ASSERT_IMPL(a_drop_zero, out_valid_q && (status_q != ST_FORWARD), (itf_q == 4'h0) && (hop_q == 32'h0) && (ttl_q == 8'h0))
  `ILPR_ASSERT_IMPL(a_fwd_ttl, out_valid_q && (status_q == ST_FORWARD), ttl_q != 8'h0)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ilpr_pkg::*;

  localparam int TableDepth   = 64;
  localparam int IdxW         = $clog2(TableDepth);
  localparam int NumIf        = 16;
  localparam int ChainLatency = TableDepth + 1;
  localparam int CycleLimit   = 400000;
  localparam int MaxReports   = 10;

  // one input word as the sender sees it
  typedef struct {
    func_e       func;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        has_nh;
    logic [31:0] gw;
    logic [3:0]  itf;
    logic [31:0] dst;
    logic [7:0]  ttl;
  } route_word_t;

  // one result word
  typedef struct {
    status_e     status;
    logic [3:0]  itf;
    logic [31:0] hop;
    logic [7:0]  ttl;
  } route_result_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic        func_i            = 1'b0;
  logic [31:0] route_prefix_i    = '0;
  logic [5:0]  prefix_length_i   = '0;
  logic        has_next_hop_i    = 1'b0;
  logic [31:0] gateway_addr_i    = '0;
  logic [3:0]  interface_index_i = '0;
  logic [31:0] dst_addr_i        = '0;
  logic [7:0]  ttl_in_i          = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  out_interface_o;
  logic [31:0] next_hop_addr_o;
  logic [7:0]  ttl_out_o;

  // shadow route table
  logic [31:0] tbl_prefix [TableDepth];
  logic [5:0]  tbl_len    [TableDepth];
  logic [32:0] tbl_gw     [TableDepth];
  logic [3:0]  tbl_itf    [TableDepth];
  int          tbl_count = 0;

  route_result_t expected_routes[$];
  int            mismatches         = 0;
  int            sender_idle_pct    = 0;
  int            receiver_stall_pct = 0;
  int unsigned   cycle_count        = 0;

  ipv4_longest_prefix_router_top #(
    .TABLE_DEPTH   (TableDepth),
    .NUM_INTERFACES(NumIf)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .route_prefix_i   (route_prefix_i),
    .prefix_length_i  (prefix_length_i),
    .has_next_hop_i   (has_next_hop_i),
    .gateway_addr_i   (gateway_addr_i),
    .interface_index_i(interface_index_i),
    .dst_addr_i       (dst_addr_i),
    .ttl_in_i         (ttl_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_interface_o  (out_interface_o),
    .next_hop_addr_o  (next_hop_addr_o),
    .ttl_out_o        (ttl_out_o)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** ipv4_longest_prefix_router_top: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // high-order mask, lengths above 32 count as 32
  function automatic logic [31:0] prefix_mask(logic [5:0] len);
    logic [31:0] m;
    m = (len == 6'd0) ? 32'h0 : ~(32'hffff_ffff >> ((len > 6'd32) ? 6'd32 : len));
    return m;
  endfunction

  // append a route or look up a destination, returns the expected word
  function automatic route_result_t lookup_or_append(route_word_t w);
    route_result_t  r;
    logic [31:0]    m;
    bit             hit;
    logic [IdxW-1:0] best;
    logic [IdxW-1:0] slot;
    r.status = ST_NO_ROUTE;
    r.itf    = '0;
    r.hop    = '0;
    r.ttl    = '0;
    hit      = 1'b0;
    best     = '0;
    if (w.func == FUNC_ADD) begin
      if (tbl_count >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        slot             = IdxW'(tbl_count);
        tbl_prefix[slot] = w.prefix;
        tbl_len[slot]    = (w.len > 6'd32) ? 6'd32 : w.len;
        tbl_gw[slot]     = {w.has_nh, w.gw};
        tbl_itf[slot]    = w.itf;
        tbl_count++;
        r.status = ST_ADDED;
      end
    end else begin
      // longest match wins, the earliest route among equal lengths
      for (int i = 0; i < tbl_count; i++) begin
        slot = IdxW'(i);
        m    = prefix_mask(tbl_len[slot]);
        if ((w.dst & m) == (tbl_prefix[slot] & m) &&
            (!hit || tbl_len[slot] > tbl_len[best])) begin
          hit  = 1'b1;
          best = slot;
        end
      end
      if (!hit || int'(tbl_itf[best]) >= NumIf) begin
        r.status = ST_NO_ROUTE;
      end else if (w.ttl <= 8'd1) begin
        r.status = ST_TTL;
      end else begin
        r.status = ST_FORWARD;
        r.itf    = tbl_itf[best];
        r.hop    = tbl_gw[best][32] ? tbl_gw[best][31:0] : w.dst;
        r.ttl    = w.ttl - 8'd1;
      end
    end
    return r;
  endfunction

  // all fields random
  function automatic route_word_t random_word();
    route_word_t w;
    w.func   = ($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_ROUTE;
    w.prefix = $urandom;
    w.len    = 6'($urandom_range(0, 63));
    w.has_nh = 1'($urandom_range(0, 1));
    w.gw     = $urandom;
    w.itf    = 4'($urandom_range(0, 15));
    w.dst    = $urandom;
    w.ttl    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic route_word_t make_add(logic [31:0] prefix, logic [5:0] len,
                                           logic has_nh, logic [31:0] gw, logic [3:0] itf);
    route_word_t w;
    w        = random_word();
    w.func   = FUNC_ADD;
    w.prefix = prefix;
    w.len    = len;
    w.has_nh = has_nh;
    w.gw     = gw;
    w.itf    = itf;
    return w;
  endfunction

  function automatic route_word_t make_lookup(logic [31:0] dst, logic [7:0] ttl);
    route_word_t w;
    w      = random_word();
    w.func = FUNC_ROUTE;
    w.dst  = dst;
    w.ttl  = ttl;
    return w;
  endfunction

  // new route, often nested under or tied with a stored one
  function automatic route_word_t random_add();
    route_word_t     w;
    logic [IdxW-1:0] k;
    logic [31:0]     m;
    w      = random_word();
    w.func = FUNC_ADD;
    if (tbl_count > 0 && $urandom_range(0, 9) < 4) begin
      k        = IdxW'($urandom_range(0, tbl_count - 1));
      m        = prefix_mask(tbl_len[k]);
      w.prefix = (tbl_prefix[k] & m) | (w.prefix & ~m);
      w.len    = 6'($urandom_range(tbl_len[k], 32));
    end else if ($urandom_range(0, 7) == 0) begin
      w.len = 6'($urandom_range(33, 63));
    end else begin
      w.len = 6'($urandom_range(1, 32));
    end
    return w;
  endfunction

  // destination mostly inside a stored prefix
  function automatic route_word_t random_lookup();
    route_word_t     w;
    logic [IdxW-1:0] k;
    logic [31:0]     m;
    w = make_lookup($urandom, 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                             : $urandom_range(2, 255)));
    if (tbl_count > 0 && $urandom_range(0, 9) < 8) begin
      k     = IdxW'($urandom_range(0, tbl_count - 1));
      m     = prefix_mask(tbl_len[k]);
      w.dst = (tbl_prefix[k] & m) | (w.dst & ~m);
    end
    return w;
  endfunction

  // drive one word and hold it until accepted
  task automatic send_word(route_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    func_i            <= w.func;
    route_prefix_i    <= w.prefix;
    prefix_length_i   <= w.len;
    has_next_hop_i    <= w.has_nh;
    gateway_addr_i    <= w.gw;
    interface_index_i <= w.itf;
    dst_addr_i        <= w.dst;
    ttl_in_i          <= w.ttl;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_routes.insert(expected_routes.size(), lookup_or_append(w));
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    route_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result word: status %0d itf %0d hop %h ttl %0d",
                   status_o, out_interface_o, next_hop_addr_o, ttl_out_o);
        end
      end else begin
        exp_r = expected_routes.pop_front();
        if (status_o !== exp_r.status || out_interface_o !== exp_r.itf ||
            next_hop_addr_o !== exp_r.hop || ttl_out_o !== exp_r.ttl) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display({"result mismatch (exp/got): ",
                      "status %0d/%0d itf %0d/%0d hop %h/%h ttl %0d/%0d"},
                     exp_r.status, status_o, exp_r.itf, out_interface_o,
                     exp_r.hop, next_hop_addr_o, exp_r.ttl, ttl_out_o);
          end
        end
      end
    end
  end

  // empty table, field extremes, ties, overlong lengths, expired ttl
  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_word(make_lookup(32'h0000_0000, 8'd255));
    send_word(make_lookup(32'hffff_ffff, 8'd0));
    send_word(make_add(32'h0a00_0000, 6'd8, 1'b1, 32'hffff_ffff, 4'd15));
    send_word(make_add(32'h0a01_0000, 6'd16, 1'b0, 32'h0000_0000, 4'd0));
    send_word(make_add(32'h0a01_0203, 6'd32, 1'b1, 32'h0000_0000, 4'd7));
    send_word(make_add(32'hc0a8_0000, 6'd33, 1'b0, 32'h1234_5678, 4'd3));
    send_word(make_add(32'h0a01_ffff, 6'd16, 1'b1, 32'h0102_0304, 4'd9));
    send_word(make_add(32'hffff_ffff, 6'd63, 1'b1, 32'haaaa_5555, 4'd1));
    send_word(make_add(32'h0000_0000, 6'd32, 1'b0, 32'h5555_aaaa, 4'd12));
    send_word(make_lookup(32'h0a09_0909, 8'd255));
    send_word(make_lookup(32'h0a01_0505, 8'd2));
    send_word(make_lookup(32'h0a01_0203, 8'd64));
    send_word(make_lookup(32'h0a01_0203, 8'd1));
    send_word(make_lookup(32'h0a01_0203, 8'd0));
    send_word(make_lookup(32'hc0a8_0000, 8'd10));
    send_word(make_lookup(32'hc0a8_0001, 8'd10));
    send_word(make_lookup(32'hffff_ffff, 8'd255));
    send_word(make_lookup(32'h0000_0000, 8'd255));
    send_word(make_lookup(32'h0b00_0000, 8'd200));
  endtask

  // mixed adds and lookups, one slot kept free for the default route
  task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) begin
      if (tbl_count < TableDepth - 1 && $urandom_range(0, 99) < 25) begin
        send_word(random_add());
      end else begin
        send_word(random_lookup());
      end
    end
  endtask

  // default route in the last cell, then adds and lookups against a full table
  task automatic test_table_full();
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    while (tbl_count < TableDepth - 1) send_word(random_add());
    send_word(make_add($urandom, 6'd0, 1'b0, $urandom, 4'd15));
    send_word(make_add($urandom, 6'd0, 1'b1, $urandom, 4'd0));
    repeat (4) send_word(random_add());
    repeat (12) send_word(random_lookup());
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(330, 0, 0);
    test_random_traffic(330, 58, 0);
    test_random_traffic(330, 0, 58);
    test_random_traffic(330, 38, 38);
    test_table_full();
    in_valid_i <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (2 * ChainLatency) @(posedge clk_i);
    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("** ipv4_longest_prefix_router_top: PASSED **");
    end else begin
      $display("** ipv4_longest_prefix_router_top: FAILED **");
    end
    $finish;
  end

endmodule
